[hdl/pia_pkg.sv]
// Shared types, constants and the source level lookup of the interrupt arbiter.
`default_nettype none

package pia_pkg;

   localparam int SOURCE_COUNT_DEF = 18;
   localparam int TRAP_COUNT_DEF   = 16;

   localparam int SOURCE_CODE_W = 5;
   localparam int TRAP_NUMBER_W = 4;
   localparam int MASK_W        = 3;
   localparam int EXC_CODE_W    = 2;
   localparam int INDEX_W       = 5;
   localparam int REG_W         = 8;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [REG_W-1:0]      IRQ0_ENABLE    = 8'h20;
   localparam logic [REG_W-1:0]      IRQ1_ENABLE    = 8'h40;
   localparam logic [MASK_W-1:0]     NMI_MASK       = 3'd7;
   localparam logic [EXC_CODE_W-1:0] EXC_CODE_COUNT = 2'd3;
   localparam logic [SOURCE_CODE_W-1:0] SRC_NMI     = 5'd0;

   typedef enum logic [1:0] {
      OP_REQUEST   = 2'd0,
      OP_EXCEPTION = 2'd1,
      OP_TRAP      = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE      = 3'd0,
      KIND_TRAP      = 3'd1,
      KIND_EXCEPTION = 3'd2,
      KIND_NMI       = 3'd3,
      KIND_MASKABLE  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      REG_PRIORITY_A   = 3'd0,
      REG_PRIORITY_B   = 3'd1,
      REG_PRIORITY_C   = 3'd2,
      REG_PRIORITY_D   = 3'd3,
      REG_PORT_CONTROL = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [REG_W-1:0] priority_a;
      logic [REG_W-1:0] priority_b;
      logic [REG_W-1:0] priority_c;
      logic [REG_W-1:0] priority_d;
      logic [REG_W-1:0] port_control;
   } csr_type;

   function automatic logic [MASK_W-1:0] hi_level(input logic [REG_W-1:0] r);
      return r[6:4];
   endfunction

   function automatic logic [MASK_W-1:0] lo_level(input logic [REG_W-1:0] r);
      return r[2:0];
   endfunction

   // Level zero means a maskable source is never served.
   function automatic logic [MASK_W-1:0] source_level(input logic [SOURCE_CODE_W-1:0] src,
                                                      input csr_type csr);
      logic [MASK_W-1:0] lvl;
      lvl = '0;
      case (src) inside
         5'd1:                lvl = ((csr.port_control & IRQ0_ENABLE) != '0) ?
                                    hi_level(csr.priority_a) : '0;
         5'd2:                lvl = ((csr.port_control & IRQ1_ENABLE) != '0) ?
                                    lo_level(csr.priority_a) : '0;
         5'd3, 5'd4, 5'd5:    lvl = hi_level(csr.priority_b);
         5'd6, 5'd7, 5'd8:    lvl = lo_level(csr.priority_b);
         5'd9, 5'd10, 5'd11:  lvl = hi_level(csr.priority_c);
         5'd12, 5'd13, 5'd14: lvl = lo_level(csr.priority_c);
         5'd15:               lvl = lo_level(csr.priority_d);
         5'd16, 5'd17:        lvl = hi_level(csr.priority_d);
         default:             lvl = '0;
      endcase
      return lvl;
   endfunction

endpackage

`default_nettype wire

[hdl/prioritized_interrupt_arbiter.sv]
// Top level of the prioritized interrupt arbiter: pending sets, service selection, CSRs.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  operation, source, level, exception, trap, mask
//   rsp      out        rsp_valid/rsp_ready  serviced, kind, index, new mask, mask loaded
//   csr      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle while the result is not stalled: an item waits in the input register,
// then the selection over the pending sets runs and lands in the result register.
// Synchronous reset clears the pending sets, the CSRs and both valid flags.
// A stalled result holds the result register; the input register still drains into it
// as soon as the result is taken, and req_ready follows that.
`default_nettype none

module prioritized_interrupt_arbiter #(
   parameter int SOURCE_COUNT = pia_pkg::SOURCE_COUNT_DEF,
   parameter int TRAP_COUNT   = pia_pkg::TRAP_COUNT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [1:0]                        req_operation,
   input  wire logic [pia_pkg::SOURCE_CODE_W-1:0] req_source_code,
   input  wire logic                              req_request_level,
   input  wire logic [pia_pkg::EXC_CODE_W-1:0]    req_exception_code,
   input  wire logic [pia_pkg::TRAP_NUMBER_W-1:0] req_trap_number,
   input  wire logic [pia_pkg::MASK_W-1:0]        req_current_mask,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic                              rsp_serviced,
   output      logic [2:0]                        rsp_service_kind,
   output      logic [pia_pkg::INDEX_W-1:0]       rsp_service_index,
   output      logic [pia_pkg::MASK_W-1:0]        rsp_new_mask,
   output      logic                              rsp_mask_loaded,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [pia_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [pia_pkg::CSR_DATA_W-1:0]    pwdata,
   output      logic [pia_pkg::CSR_DATA_W-1:0]    prdata,
   output      logic                              pready
);
   import pia_pkg::*;

   // CSRs
   csr_type          csr_ff;
   reg_index_type    csr_index;
   logic             csr_write;

   // input register
   logic                     s1_valid_ff;
   op_type                   s1_op_ff;
   logic [SOURCE_CODE_W-1:0] s1_src_ff;
   logic                     s1_level_ff;
   logic [EXC_CODE_W-1:0]    s1_exc_ff;
   logic [TRAP_NUMBER_W-1:0] s1_trap_ff;
   logic [MASK_W-1:0]        s1_mask_ff;

   // pending state
   logic [SOURCE_COUNT-1:0]  request_pending_ff, request_pending_in;
   logic [TRAP_COUNT-1:0]    trap_pending_ff, trap_pending_in;
   logic                     exception_valid_ff, exception_valid_in;
   logic [EXC_CODE_W-1:0]    exception_kind_ff, exception_kind_in;

   // result register
   logic                     rsp_valid_ff;
   logic                     serviced_ff, serviced_in;
   kind_type                 kind_ff, kind_in;
   logic [INDEX_W-1:0]       index_ff, index_in;
   logic [MASK_W-1:0]        new_mask_ff, new_mask_in;
   logic                     loaded_ff, loaded_in;

   logic                     advance;
   logic                     req_take;

   // selection
   logic [SOURCE_COUNT-1:0]  src_hit;
   logic [TRAP_COUNT-1:0]    trap_hit;
   logic [SOURCE_COUNT-1:0]  eligible;
   logic [MASK_W-1:0]        level [SOURCE_COUNT];
   logic                     trap_any;
   logic [TRAP_NUMBER_W-1:0] trap_first;
   logic                     irq_any;
   logic [INDEX_W-1:0]       irq_first;
   logic [MASK_W-1:0]        irq_level;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PRIORITY_A:   csr_ff.priority_a   <= pwdata[REG_W-1:0];
            REG_PRIORITY_B:   csr_ff.priority_b   <= pwdata[REG_W-1:0];
            REG_PRIORITY_C:   csr_ff.priority_c   <= pwdata[REG_W-1:0];
            REG_PRIORITY_D:   csr_ff.priority_d   <= pwdata[REG_W-1:0];
            REG_PORT_CONTROL: csr_ff.port_control <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_PRIORITY_A:   prdata[REG_W-1:0] = csr_ff.priority_a;
         REG_PRIORITY_B:   prdata[REG_W-1:0] = csr_ff.priority_b;
         REG_PRIORITY_C:   prdata[REG_W-1:0] = csr_ff.priority_c;
         REG_PRIORITY_D:   prdata[REG_W-1:0] = csr_ff.priority_d;
         REG_PORT_CONTROL: prdata[REG_W-1:0] = csr_ff.port_control;
         default:          prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= op_type'(req_operation);
         s1_src_ff   <= req_source_code;
         s1_level_ff <= req_request_level;
         s1_exc_ff   <= req_exception_code;
         s1_trap_ff  <= req_trap_number;
         s1_mask_ff  <= req_current_mask;
      end
   end

   // ---------------- selection and state update ----------------
   always_comb begin
      for (int i = 0; i < SOURCE_COUNT; i++) begin
         src_hit[i] = (s1_src_ff == SOURCE_CODE_W'(i));
         level[i]   = source_level(SOURCE_CODE_W'(i), csr_ff);
         eligible[i] = (i != 0) && request_pending_ff[i] && (level[i] > s1_mask_ff);
      end
      for (int i = 0; i < TRAP_COUNT; i++) begin
         trap_hit[i] = (s1_trap_ff == TRAP_NUMBER_W'(i));
      end

      // lowest set bit wins: scan downward so the last hit stands
      trap_any   = |trap_pending_ff;
      trap_first = '0;
      for (int i = TRAP_COUNT - 1; i >= 0; i--) begin
         if (trap_pending_ff[i]) trap_first = TRAP_NUMBER_W'(i);
      end
      irq_any   = |eligible;
      irq_first = '0;
      irq_level = '0;
      for (int i = SOURCE_COUNT - 1; i >= 1; i--) begin
         if (eligible[i]) begin
            irq_first = INDEX_W'(i);
            irq_level = level[i];
         end
      end

      request_pending_in = request_pending_ff;
      trap_pending_in    = trap_pending_ff;
      exception_valid_in = exception_valid_ff;
      exception_kind_in  = exception_kind_ff;
      serviced_in        = 1'b0;
      kind_in            = KIND_NONE;
      index_in           = '0;
      new_mask_in        = '0;
      loaded_in          = 1'b0;

      unique case (s1_op_ff)
         OP_REQUEST: begin
            // codes beyond the source count match no bit and drop out
            if (s1_level_ff) request_pending_in = request_pending_ff | src_hit;
            else             request_pending_in = request_pending_ff & ~src_hit;
         end
         OP_EXCEPTION: begin
            if (s1_exc_ff < EXC_CODE_COUNT) begin
               exception_valid_in = 1'b1;
               exception_kind_in  = s1_exc_ff;
            end
         end
         OP_TRAP: begin
            trap_pending_in = trap_pending_ff | trap_hit;
         end
         OP_QUERY: begin
            if (trap_any) begin
               trap_pending_in = trap_pending_ff & ~(TRAP_COUNT'(1) << trap_first);
               serviced_in     = 1'b1;
               kind_in         = KIND_TRAP;
               index_in        = INDEX_W'(trap_first);
               new_mask_in     = s1_mask_ff;
            end else if (exception_valid_ff) begin
               exception_valid_in = 1'b0;
               serviced_in        = 1'b1;
               kind_in            = KIND_EXCEPTION;
               index_in           = INDEX_W'(exception_kind_ff);
               new_mask_in        = s1_mask_ff;
            end else if (request_pending_ff[0]) begin
               serviced_in = 1'b1;
               kind_in     = KIND_NMI;
               index_in    = INDEX_W'(SRC_NMI);
               new_mask_in = NMI_MASK;
               loaded_in   = 1'b1;
            end else if (irq_any) begin
               serviced_in = 1'b1;
               kind_in     = KIND_MASKABLE;
               index_in    = irq_first;
               new_mask_in = irq_level;
               loaded_in   = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         request_pending_ff <= '0;
         trap_pending_ff    <= '0;
         exception_valid_ff <= 1'b0;
         exception_kind_ff  <= '0;
      end else if (advance) begin
         request_pending_ff <= request_pending_in;
         trap_pending_ff    <= trap_pending_in;
         exception_valid_ff <= exception_valid_in;
         exception_kind_ff  <= exception_kind_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         serviced_ff <= serviced_in;
         kind_ff     <= kind_in;
         index_ff    <= index_in;
         new_mask_ff <= new_mask_in;
         loaded_ff   <= loaded_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_serviced      = serviced_ff;
   assign rsp_service_kind  = kind_ff;
   assign rsp_service_index = index_ff;
   assign rsp_new_mask      = new_mask_ff;
   assign rsp_mask_loaded   = loaded_ff;

   // ---------------- assertions ----------------
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !rsp_valid_ff) |-> req_ready)
      else $error("input refused with both stages empty");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !serviced_ff) |->
      (kind_ff == KIND_NONE && index_ff == '0 && new_mask_ff == '0 && !loaded_ff))
      else $error("unserviced result carries data");

   a_nmi_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_NMI) |-> (loaded_ff && new_mask_ff == NMI_MASK))
      else $error("NMI result without full mask");

   a_exc_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in == KIND_EXCEPTION) |=> !exception_valid_ff)
      else $error("served exception still pending");

   a_trap_first: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_in == KIND_TRAP) |=> !trap_pending_ff[$past(trap_first)])
      else $error("served trap still pending");

endmodule

`default_nettype wire
